// ===== rtl/core/int64_divide_modulo_core_macros.svh =====
// Assertion macros shared by the divider RTL.
// Defining ASSERT_OFF turns every check into an empty statement.
`ifndef INT64_DIVIDE_MODULO_CORE_MACROS_SVH
`define INT64_DIVIDE_MODULO_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Checks a property on every rising clock edge outside reset.
`define IDM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");

// Checks that a condition is followed by a consequence.
`define IDM_ASSERT_IMPLY(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("%m: implication failed");

`else

`define IDM_ASSERT(label, clk, rst, prop)
`define IDM_ASSERT_IMPLY(label, clk, rst, cond, cons)

`endif

`endif

// ===== rtl/core/idm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the pipelined integer divider.
// No dependencies; every divider module imports this package.
package idm_pkg;

   // Width of the operand and result ports.
   localparam int FIELD_WIDTH   = 64;
   // Default arithmetic width of the datapath.
   localparam int DEFAULT_WIDTH = 64;
   localparam int OP_WIDTH      = 2;

   // Operation codes.
   localparam logic [OP_WIDTH-1:0] OP_UQUO = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_UREM = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_SQUO = 2'd2;
   localparam logic [OP_WIDTH-1:0] OP_SREM = 2'd3;

   // Control that travels alongside the data through every stage.
   typedef struct packed {
      logic                valid;
      logic [OP_WIDTH-1:0] op;
      logic                nneg;   // dividend negative, signed operation
      logic                dneg;   // divisor negative, signed operation
      logic                dzero;  // divisor is zero
   } ctl_type;

endpackage

// ===== rtl/core/idm_prep.sv =====
`timescale 1ns / 1ps
// Input stage: registers a transfer and turns signed operands into magnitudes.
// Depends on idm_pkg.
module idm_prep import idm_pkg::*; #(
   parameter int DATA_WIDTH = DEFAULT_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [OP_WIDTH-1:0]    operation,
   input  logic [FIELD_WIDTH-1:0] dividend,
   input  logic [FIELD_WIDTH-1:0] divisor,
   output ctl_type                ctl_o,
   output logic [DATA_WIDTH-1:0]  num_o,
   output logic [DATA_WIDTH-1:0]  den_o
);

   logic [DATA_WIDTH-1:0] n;
   logic [DATA_WIDTH-1:0] d;
   logic                  is_signed;
   ctl_type               ctl_in;
   ctl_type               ctl_ff;
   logic [DATA_WIDTH-1:0] num_in;
   logic [DATA_WIDTH-1:0] num_ff;
   logic [DATA_WIDTH-1:0] den_in;
   logic [DATA_WIDTH-1:0] den_ff;

   assign n = dividend[DATA_WIDTH-1:0];
   assign d = divisor[DATA_WIDTH-1:0];

   // Sign flags and magnitudes; unsigned operations pass the bits through.
   always_comb begin
      unique case (operation)
         OP_SQUO, OP_SREM: is_signed = 1'b1;
         default:          is_signed = 1'b0;
      endcase
      ctl_in.valid = accept;
      ctl_in.op    = operation;
      ctl_in.nneg  = is_signed & n[DATA_WIDTH-1];
      ctl_in.dneg  = is_signed & d[DATA_WIDTH-1];
      ctl_in.dzero = (d == '0);
      num_in       = ctl_in.nneg ? (~n + 1'b1) : n;
      den_in       = ctl_in.dneg ? (~d + 1'b1) : d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign ctl_o = ctl_ff;
   assign num_o = num_ff;
   assign den_o = den_ff;

endmodule

// ===== rtl/core/idm_step.sv =====
`timescale 1ns / 1ps
// One restoring division step: shift in a dividend bit, trial subtract, register.
// Depends on idm_pkg.
module idm_step import idm_pkg::*; #(
   parameter int DATA_WIDTH = DEFAULT_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_type               ctl_i,
   input  logic [DATA_WIDTH-1:0] num_i,
   input  logic [DATA_WIDTH-1:0] rem_i,
   input  logic [DATA_WIDTH-1:0] den_i,
   output ctl_type               ctl_o,
   output logic [DATA_WIDTH-1:0] num_o,
   output logic [DATA_WIDTH-1:0] rem_o,
   output logic [DATA_WIDTH-1:0] den_o
);

   logic [DATA_WIDTH+1:0] diff;
   logic                  take;
   ctl_type               ctl_ff;
   logic [DATA_WIDTH-1:0] num_in;
   logic [DATA_WIDTH-1:0] num_ff;
   logic [DATA_WIDTH-1:0] rem_in;
   logic [DATA_WIDTH-1:0] rem_ff;
   logic [DATA_WIDTH-1:0] den_ff;

   // The shifted remainder keeps its carry bit, so the compare never overflows.
   // The dividend register fills with quotient bits from the bottom as it empties.
   always_comb begin
      diff   = {1'b0, rem_i, num_i[DATA_WIDTH-1]} - {2'b00, den_i};
      take   = ~diff[DATA_WIDTH+1];
      rem_in = take ? diff[DATA_WIDTH-1:0] : {rem_i[DATA_WIDTH-2:0], num_i[DATA_WIDTH-1]};
      num_in = {num_i[DATA_WIDTH-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_i;
   end

   assign ctl_o = ctl_ff;
   assign num_o = num_ff;
   assign rem_o = rem_ff;
   assign den_o = den_ff;

endmodule

// ===== rtl/core/idm_post.sv =====
`timescale 1ns / 1ps
// Output stage: selects quotient or remainder, applies signs and divide-by-zero.
// Depends on idm_pkg.
module idm_post import idm_pkg::*; #(
   parameter int DATA_WIDTH = DEFAULT_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctl_type                ctl_i,
   input  logic [DATA_WIDTH-1:0]  quo_i,
   input  logic [DATA_WIDTH-1:0]  rem_i,
   output logic                   rsp_valid,
   output logic [FIELD_WIDTH-1:0] rsp_result
);

   logic [DATA_WIDTH-1:0]  res;
   logic                   valid_ff;
   logic [FIELD_WIDTH-1:0] result_in;
   logic [FIELD_WIDTH-1:0] result_ff;

   // A zero divisor makes the raw quotient all ones; it is forced to zero.
   // The raw remainder already equals the dividend magnitude in that case.
   always_comb begin
      unique case (ctl_i.op)
         OP_UQUO: res = ctl_i.dzero ? '0 : quo_i;
         OP_UREM: res = rem_i;
         OP_SQUO: begin
            if (ctl_i.dzero) begin
               res = '0;
            end else begin
               res = (ctl_i.nneg ^ ctl_i.dneg) ? (~quo_i + 1'b1) : quo_i;
            end
         end
         OP_SREM: res = ctl_i.nneg ? (~rem_i + 1'b1) : rem_i;
         default: res = '0;
      endcase
      result_in = FIELD_WIDTH'(res);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

// ===== rtl/core/int64_divide_modulo_core.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: signed and unsigned quotient and remainder.
// One input stage, one stage per quotient bit and one output stage, all registered.
// A new transfer is taken every cycle; busy stays low.
// Synchronous reset clears every stage's valid bit; results are never stalled.
// Depends on idm_pkg, idm_prep, idm_step, idm_post and the assertion macro header.
`include "int64_divide_modulo_core_macros.svh"
module int64_divide_modulo_core import idm_pkg::*; #(
   parameter int DATA_WIDTH = DEFAULT_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [OP_WIDTH-1:0]    req_operation,
   input  logic [FIELD_WIDTH-1:0] req_dividend,
   input  logic [FIELD_WIDTH-1:0] req_divisor,
   output logic                   rsp_valid,
   output logic [FIELD_WIDTH-1:0] rsp_result
);

   localparam int LATENCY = DATA_WIDTH + 2;

   ctl_type               ctl [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] num [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] rem [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] den [DATA_WIDTH+1];
   logic                  accept;

   // Every stage advances each cycle, so the pipeline never refuses a transfer.
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   idm_prep #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .operation(req_operation),
      .dividend (req_dividend),
      .divisor  (req_divisor),
      .ctl_o    (ctl[0]),
      .num_o    (num[0]),
      .den_o    (den[0])
   );

   assign rem[0] = '0;

   // One registered stage per quotient bit, most significant first.
   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
      idm_step #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_step (
         .clock(clock),
         .reset(reset),
         .ctl_i(ctl[i]),
         .num_i(num[i]),
         .rem_i(rem[i]),
         .den_i(den[i]),
         .ctl_o(ctl[i+1]),
         .num_o(num[i+1]),
         .rem_o(rem[i+1]),
         .den_o(den[i+1])
      );
   end

   idm_post #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_post (
      .clock     (clock),
      .reset     (reset),
      .ctl_i     (ctl[DATA_WIDTH]),
      .quo_i     (num[DATA_WIDTH]),
      .rem_i     (rem[DATA_WIDTH]),
      .rsp_valid (rsp_valid),
      .rsp_result(rsp_result)
   );

   // Every accepted transfer yields a strobe after the full pipeline depth.
   `IDM_ASSERT_IMPLY(a_result_follows, clock, reset, accept, ##LATENCY rsp_valid)
   // A strobe only appears for a transfer accepted exactly that long ago.
   `IDM_ASSERT_IMPLY(a_no_spurious, clock, reset, rsp_valid, $past(accept, LATENCY))
   // An unsigned quotient by zero comes out as zero.
   `IDM_ASSERT_IMPLY(a_div_zero_quo, clock, reset,
      accept && req_operation == OP_UQUO && req_divisor[DATA_WIDTH-1:0] == '0,
      ##LATENCY rsp_result == '0)

endmodule
